>>> design/hbbc_pkg.sv
// Package with shared types and constants of the block buffer cache tag table.
`timescale 1ns / 1ps
package hbbc_pkg;
	localparam int NumSlots = 32;
	localparam int NumBuckets = 17;
	localparam int SlotW = 5;
	localparam int BucketW = 5;
	localparam int RankW = 5;
	localparam logic [7:0] CountMax = 8'd255;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN = 2'd2,
		CMD_UNPIN = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;       // capture the request and compute the bucket
		logic clr_idx;    // restart the slot scan
		logic scan_hit;   // examine the current slot for a tag match
		logic scan_free;  // examine the current slot for a never-used free slot
		logic scan_old;   // examine the current slot as an old victim
		logic next_bucket;// advance the bucket under search
		logic inc_idx;
		logic do_hit;     // apply the hit update
		logic do_count;   // apply release, pin or unpin
		logic prep_alloc; // latch the victim fields
		logic fix_rank;   // rank fix-up of the current slot
		logic do_alloc;   // write the victim entry
		logic do_fail;    // no victim
		logic out_load;
	} cmd_bus_t;

	typedef struct packed {
		logic       last_idx;
		logic       hit_found;
		logic       victim_found;
		logic       last_bucket;
		cmd_t       command;
		logic       out_full;
	} stat_bus_t;
endpackage

>>> design/hbbc_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface hbbc_req_if (input logic clk);
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  device_id;
	logic [31:0] block_number;
	logic [4:0]  slot_index;
	modport source (output valid, command, device_id, block_number, slot_index, input ready);
	modport sink (input valid, command, device_id, block_number, slot_index, output ready);
endinterface

interface hbbc_rsp_if (input logic clk);
	logic       valid;
	logic       ready;
	logic [4:0] slot;
	logic       needs_read;
	logic [1:0] status;
	modport source (output valid, slot, needs_read, status, input ready);
	modport sink (input valid, slot, needs_read, status, output ready);
endinterface

>>> design/hbbc_mod17.sv
// Serial reduction of a 32-bit value modulo 17, four bits a cycle.
`timescale 1ns / 1ps
module hbbc_mod17 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	output logic        done,
	output logic [4:0]  rem
);
	logic [31:0] sh_q;
	logic [3:0]  cnt_q;
	logic [4:0]  r_q;
	logic        busy_q;
	logic [8:0]  nxt;

	// r*16 + nibble; r<17 so value < 288, reduce by trial subtracts.
	always_comb begin
		nxt = {r_q, 4'b0} + {5'b0, sh_q[31:28]};
		if (nxt >= 9'd272) nxt = nxt - 9'd272;
		if (nxt >= 9'd136) nxt = nxt - 9'd136;
		if (nxt >= 9'd68) nxt = nxt - 9'd68;
		if (nxt >= 9'd34) nxt = nxt - 9'd34;
		if (nxt >= 9'd17) nxt = nxt - 9'd17;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd7) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= value;
			r_q <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[27:0], 4'b0};
			r_q <= nxt[4:0];
		end
	end

	assign rem = r_q;
endmodule

>>> design/hbbc_datapath.sv
// Tag table storage, slot scans and update logic of the buffer cache.
`timescale 1ns / 1ps
module hbbc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  hbbc_pkg::cmd_bus_t  cmd,
	input  logic                hash_done,
	input  logic [4:0]          hash_rem,
	output hbbc_pkg::stat_bus_t stat,
	hbbc_req_if.sink            req,
	hbbc_rsp_if.source          rsp
);
	localparam int N = hbbc_pkg::NumSlots;
	localparam int SW = hbbc_pkg::SlotW;

	logic [7:0]  tag_dev_q [N];
	logic [31:0] tag_blk_q [N];
	logic [7:0]  cnt_q [N];
	logic [N-1:0] valid_q;
	logic [N-1:0] used_q;
	logic [4:0]  bkt_q [N];
	logic [4:0]  rank_q [N];

	hbbc_pkg::cmd_t cmd_q;
	logic [7:0]  dev_q;
	logic [31:0] blk_q;
	logic [SW-1:0] sidx_q;
	logic [4:0]  b_q;        // bucket of the request
	logic [4:0]  sb_q;       // bucket under victim search
	logic [SW-1:0] idx_q;
	logic        found_q;
	logic [SW-1:0] best_q;
	logic [4:0]  best_rank_q;
	logic [4:0]  old_bkt_q;
	logic [4:0]  old_rank_q;
	logic        old_used_q;

	logic [SW-1:0] o_slot_q;
	logic          o_need_q;
	hbbc_pkg::status_t o_st_q;
	logic          o_valid_q;

	logic [7:0] c_best;
	logic [7:0] c_sidx;
	assign c_best = cnt_q[best_q];
	assign c_sidx = cnt_q[sidx_q];

	assign req.ready = 1'b0 | (cmd.load);
	assign stat.last_idx = (idx_q == SW'(N - 1));
	assign stat.hit_found = found_q;
	assign stat.victim_found = found_q;
	assign stat.last_bucket = (sb_q == 5'(hbbc_pkg::NumBuckets - 1));
	assign stat.command = cmd_q;
	assign stat.out_full = o_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				tag_dev_q[i] <= '0;
				tag_blk_q[i] <= '0;
				cnt_q[i] <= '0;
				bkt_q[i] <= '0;
				rank_q[i] <= 5'(i);
			end
			valid_q <= '0;
			used_q <= '0;
			o_valid_q <= 1'b0;
			found_q <= 1'b0;
			idx_q <= '0;
			sb_q <= '0;
		end else begin
			if (rsp.ready && o_valid_q) o_valid_q <= 1'b0;
			if (cmd.load) begin
				cmd_q <= hbbc_pkg::cmd_t'(req.command);
				dev_q <= req.device_id;
				blk_q <= req.block_number;
				sidx_q <= req.slot_index;
			end
			if (hash_done) b_q <= hash_rem;
			if (cmd.clr_idx) begin
				idx_q <= '0;
				found_q <= 1'b0;
				sb_q <= '0;
			end
			if (cmd.inc_idx) idx_q <= idx_q + SW'(1);
			if (cmd.next_bucket) begin
				sb_q <= sb_q + 5'd1;
				idx_q <= '0;
			end
			if (cmd.scan_hit && !found_q && used_q[idx_q] && bkt_q[idx_q] == b_q
				&& tag_dev_q[idx_q] == dev_q && tag_blk_q[idx_q] == blk_q) begin
				found_q <= 1'b1;
				best_q <= idx_q;
			end
			if (cmd.scan_free && !found_q && !used_q[idx_q] && cnt_q[idx_q] == 8'd0) begin
				found_q <= 1'b1;
				best_q <= idx_q;
			end
			if (cmd.scan_old && used_q[idx_q] && bkt_q[idx_q] == sb_q
				&& cnt_q[idx_q] == 8'd0
				&& (!found_q || rank_q[idx_q] > best_rank_q)) begin
				found_q <= 1'b1;
				best_q <= idx_q;
				best_rank_q <= rank_q[idx_q];
			end
			if (cmd.do_hit) begin
				o_valid_q <= 1'b1;
				o_slot_q <= best_q;
				if (c_best >= hbbc_pkg::CountMax) begin
					o_st_q <= hbbc_pkg::ST_OVERFLOW;
					o_need_q <= 1'b0;
				end else begin
					o_st_q <= hbbc_pkg::ST_OK;
					cnt_q[best_q] <= c_best + 8'd1;
					o_need_q <= (c_best == 8'd0) ? 1'b1 : !valid_q[best_q];
					valid_q[best_q] <= 1'b1;
				end
			end
			if (cmd.do_count) begin
				o_valid_q <= 1'b1;
				o_slot_q <= sidx_q;
				o_need_q <= 1'b0;
				o_st_q <= hbbc_pkg::ST_OK;
				if (cmd_q == hbbc_pkg::CMD_PIN) begin
					if (c_sidx >= hbbc_pkg::CountMax) o_st_q <= hbbc_pkg::ST_OVERFLOW;
					else cnt_q[sidx_q] <= c_sidx + 8'd1;
				end else begin
					if (c_sidx == 8'd0) o_st_q <= hbbc_pkg::ST_ZERO;
					else cnt_q[sidx_q] <= c_sidx - 8'd1;
				end
			end
			if (cmd.prep_alloc) begin
				old_bkt_q <= bkt_q[best_q];
				old_rank_q <= rank_q[best_q];
				old_used_q <= used_q[best_q];
			end
			if (cmd.fix_rank && idx_q != best_q && used_q[idx_q]) begin
				// Leave the old bucket, then join the new one, in a single update.
				rank_q[idx_q] <= rank_q[idx_q]
					- ((old_used_q && bkt_q[idx_q] == old_bkt_q
						&& rank_q[idx_q] > old_rank_q) ? 5'd1 : 5'd0)
					+ ((bkt_q[idx_q] == b_q) ? 5'd1 : 5'd0);
			end
			if (cmd.do_alloc) begin
				tag_dev_q[best_q] <= dev_q;
				tag_blk_q[best_q] <= blk_q;
				cnt_q[best_q] <= 8'd1;
				bkt_q[best_q] <= b_q;
				rank_q[best_q] <= '0;
				used_q[best_q] <= 1'b1;
				valid_q[best_q] <= 1'b1;
				o_valid_q <= 1'b1;
				o_slot_q <= best_q;
				o_need_q <= 1'b1;
				o_st_q <= hbbc_pkg::ST_OK;
			end
			if (cmd.do_fail) begin
				o_valid_q <= 1'b1;
				o_slot_q <= '0;
				o_need_q <= 1'b0;
				o_st_q <= hbbc_pkg::ST_NO_FREE;
			end
		end
	end

	assign rsp.valid = o_valid_q;
	assign rsp.slot = o_slot_q;
	assign rsp.needs_read = o_need_q;
	assign rsp.status = o_st_q;
endmodule

>>> design/hbbc_ctrl.sv
// Controller state machine sequencing hash, scans and updates.
`timescale 1ns / 1ps
module hbbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                hash_done,
	input  hbbc_pkg::stat_bus_t stat,
	output hbbc_pkg::cmd_bus_t  cmd,
	output logic                hash_start
);
	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_DISP  = 12'b000000000010,
		S_HASH  = 12'b000000000100,
		S_HIT   = 12'b000000001000,
		S_FREE  = 12'b000000010000,
		S_OLD   = 12'b000000100000,
		S_PREP  = 12'b000001000000,
		S_FIX   = 12'b000010000000,
		S_DONE  = 12'b000100000000,
		S_ODD   = 12'b001000000000,
		S_FCHK  = 12'b010000000000,
		S_OCHK  = 12'b100000000000
	} state_t;

	state_t st_q;
	state_t st_d;

	always_comb begin
		cmd = '0;
		hash_start = 1'b0;
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (req_valid && !stat.out_full) begin
					cmd.load = 1'b1;
					st_d = S_DISP;
				end
			end
			S_DISP: begin
				cmd.clr_idx = 1'b1;
				if (stat.command == hbbc_pkg::CMD_LOOKUP) begin
					hash_start = 1'b1;
					st_d = S_HASH;
				end else begin
					st_d = S_ODD;
				end
			end
			S_ODD: begin
				cmd.do_count = 1'b1;
				st_d = S_IDLE;
			end
			S_HASH: if (hash_done) st_d = S_HIT;
			S_HIT: begin
				cmd.scan_hit = 1'b1;
				cmd.inc_idx = 1'b1;
				if (stat.last_idx) st_d = S_DONE;
			end
			S_DONE: begin
				if (stat.hit_found) begin
					cmd.do_hit = 1'b1;
					st_d = S_IDLE;
				end else begin
					cmd.clr_idx = 1'b1;
					st_d = S_FREE;
				end
			end
			S_FREE: begin
				cmd.scan_free = 1'b1;
				cmd.inc_idx = 1'b1;
				if (stat.victim_found) begin
					cmd.clr_idx = 1'b0;
					st_d = S_PREP;
				end else if (stat.last_idx) begin
					st_d = S_FCHK;
				end
			end
			// The last slot of the free scan has been examined by now.
			S_FCHK: begin
				if (stat.victim_found) begin
					st_d = S_PREP;
				end else begin
					cmd.clr_idx = 1'b1;
					st_d = S_OLD;
				end
			end
			S_OLD: begin
				cmd.scan_old = 1'b1;
				cmd.inc_idx = 1'b1;
				if (stat.last_idx) st_d = S_OCHK;
			end
			// One bucket has been scanned in full; take its oldest free slot or go on.
			S_OCHK: begin
				if (stat.victim_found) begin
					st_d = S_PREP;
				end else if (stat.last_bucket) begin
					cmd.do_fail = 1'b1;
					st_d = S_IDLE;
				end else begin
					cmd.next_bucket = 1'b1;
					st_d = S_OLD;
				end
			end
			S_PREP: begin
				cmd.prep_alloc = 1'b1;
				cmd.clr_idx = 1'b1;
				st_d = S_FIX;
			end
			S_FIX: begin
				cmd.fix_rank = 1'b1;
				cmd.inc_idx = 1'b1;
				if (stat.last_idx) begin
					cmd.do_alloc = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end
endmodule

>>> design/hashed_block_buffer_cache_top.sv
// Top level of the hashed block buffer cache tag table.
`timescale 1ns / 1ps
// The block takes one request item on req (command, device_id, block_number,
// slot_index) and gives one result item on rsp (slot, needs_read, status).
// Both channels are valid/ready; an item moves when both are high.
// Release, pin and unpin update the count of the given slot. A lookup first
// reduces the hash modulo 17, then scans all 32 slots for a tag match. A hit
// finishes there. A miss scans for a never-used slot, then if needed scans
// each bucket in turn for its oldest free slot, and finally sweeps all slots
// once more to fix the age ranks. One item is in work at a time. The result
// sits in an output register, and a new item is taken only once it has left,
// so a stalled receiver holds back requests.
// Reset clears the whole table at once: counts, tags and flags go to zero
// and each slot's age rank to its own index.
module hashed_block_buffer_cache_top (
	input logic        clk,
	input logic        arst_n,
	hbbc_req_if.sink   req,
	hbbc_rsp_if.source rsp
);
	hbbc_pkg::cmd_bus_t  cmd;
	hbbc_pkg::stat_bus_t stat;
	logic       hash_start;
	logic       hash_done;
	logic [4:0] hash_rem;
	logic [31:0] hash_in;
	logic [7:0]  dev_q;
	logic [31:0] blk_q;

	// The datapath latches the request; hash from a copy taken at load.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dev_q <= req.device_id;
			blk_q <= req.block_number;
		end
	end
	assign hash_in = {24'b0, dev_q} ^ blk_q;

	hbbc_mod17 u_mod (
		.clk(clk), .arst_n(arst_n), .start(hash_start), .value(hash_in),
		.done(hash_done), .rem(hash_rem)
	);

	hbbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .hash_done(hash_done),
		.stat(stat), .cmd(cmd), .hash_start(hash_start)
	);

	hbbc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .hash_done(hash_done),
		.hash_rem(hash_rem), .stat(stat), .req(req), .rsp(rsp)
	);
endmodule
